### rtl/lsse_pkg.sv
`default_nettype none

package lsse_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_RGB_ORDER   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_WORDS = 1'd1;

  localparam logic       RGB_ORDER_RESET   = 1'b0;
  localparam logic [5:0] RESET_WORDS_RESET = 6'd3;
  localparam logic [5:0] MAX_RESET_WORDS   = 6'd32;

  // one pixel after classification: colours already in line order
  typedef struct packed {
    logic       lead;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       last;
    logic [5:0] nreset;
  } lsse_cmd_t;

  // each data bit becomes 0001 (zero) or 0111 (one), msb sent first
  function automatic logic [15:0] nibble_line(input logic [3:0] nib);
    logic [15:0] w;
    unique case (nib)
      4'h0: w = 16'h1111;
      4'h1: w = 16'h7111;
      4'h2: w = 16'h1711;
      4'h3: w = 16'h7711;
      4'h4: w = 16'h1171;
      4'h5: w = 16'h7171;
      4'h6: w = 16'h1771;
      4'h7: w = 16'h7771;
      4'h8: w = 16'h1117;
      4'h9: w = 16'h7117;
      4'ha: w = 16'h1717;
      4'hb: w = 16'h7717;
      4'hc: w = 16'h1177;
      4'hd: w = 16'h7177;
      4'he: w = 16'h1777;
      4'hf: w = 16'h7777;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/lsse_pix_if.sv
`default_nettype none

interface lsse_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source(output valid, red, green, blue, last_pixel, input ready);
  modport sink(input valid, red, green, blue, last_pixel, output ready);
endinterface

`default_nettype wire

### rtl/lsse_word_if.sv
`default_nettype none

interface lsse_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_word;
  logic        frame_end;

  modport source(output valid, line_word, frame_end, input ready);
  modport sink(input valid, line_word, frame_end, output ready);
endinterface

`default_nettype wire

### rtl/lsse_cfg_if.sv
`default_nettype none

interface lsse_cfg_if
  import lsse_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/lsse_front.sv
`default_nettype none

module lsse_front
  import lsse_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  lsse_pix_if.sink   pix,
  lsse_cfg_if.sink   cfg,
  output lsse_cmd_t  push_cmd,
  output logic       push_valid,
  input  wire logic  push_ready
);

  logic       rgb_order_r, rgb_order_nxt;
  logic [5:0] reset_words_r, reset_words_nxt;
  logic       pending_r, pending_nxt;
  logic       accept;

  assign cfg.ready  = 1'b1;
  assign pix.ready  = push_ready;
  assign push_valid = pix.valid;
  assign accept     = pix.valid && push_ready;

  always_comb begin
    push_cmd.lead = pending_r;
    push_cmd.last = pix.last_pixel;
    push_cmd.c2   = pix.blue;
    if (rgb_order_r) begin
      push_cmd.c0 = pix.red;
      push_cmd.c1 = pix.green;
    end else begin
      push_cmd.c0 = pix.green;
      push_cmd.c1 = pix.red;
    end
    push_cmd.nreset = (reset_words_r > MAX_RESET_WORDS) ? MAX_RESET_WORDS : reset_words_r;
  end

  always_comb begin
    rgb_order_nxt   = rgb_order_r;
    reset_words_nxt = reset_words_r;
    pending_nxt     = pending_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_RGB_ORDER:   rgb_order_nxt   = cfg.data[0];
        REG_RESET_WORDS: reset_words_nxt = cfg.data[5:0];
        default: ;
      endcase
    end
    // a last pixel re-arms the leading zero word
    if (accept) pending_nxt = pix.last_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rgb_order_r   <= RGB_ORDER_RESET;
      reset_words_r <= RESET_WORDS_RESET;
      pending_r     <= 1'b1;
    end else begin
      rgb_order_r   <= rgb_order_nxt;
      reset_words_r <= reset_words_nxt;
      pending_r     <= pending_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/lsse_fifo.sv
`default_nettype none

module lsse_fifo
  import lsse_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lsse_cmd_t  push_cmd,
  input  wire logic       push_valid,
  output logic            push_ready,
  output lsse_cmd_t       pop_cmd,
  output logic            pop_valid,
  input  wire logic       pop_ready
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lsse_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/lsse_back.sv
`default_nettype none

module lsse_back
  import lsse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lsse_cmd_t  pop_cmd,
  input  wire logic       pop_valid,
  output logic            pop_ready,
  lsse_word_if.source     word
);

  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_COLOUR = 2'd1;
  localparam logic [1:0] PH_RESET  = 2'd2;

  lsse_cmd_t   cmd_r, cmd_nxt;
  logic        busy_r, busy_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_word_r, out_word_nxt;
  logic        out_end_r, out_end_nxt;

  logic        adv;
  logic        done;
  logic [15:0] emit_word;
  logic        emit_end;
  logic [7:0]  col_byte;
  logic [3:0]  nib;
  logic [5:0]  cnt_inc;

  assign word.valid     = out_valid_r;
  assign word.line_word = out_word_r;
  assign word.frame_end = out_end_r;

  assign adv       = !out_valid_r || word.ready;
  assign cnt_inc   = cnt_r + 6'd1;
  assign pop_ready = adv && (!busy_r || done);

  always_comb begin
    unique case (cnt_r[2:1])
      2'd0:    col_byte = cmd_r.c0;
      2'd1:    col_byte = cmd_r.c1;
      default: col_byte = cmd_r.c2;
    endcase
    nib = cnt_r[0] ? col_byte[3:0] : col_byte[7:4];
  end

  // word for the current step and whether this step finishes the pixel
  always_comb begin
    emit_word = '0;
    emit_end  = 1'b0;
    done      = 1'b0;
    unique case (phase_r)
      PH_LEAD: ;
      PH_COLOUR: begin
        emit_word = nibble_line(nib);
        if (cnt_r[2:0] == 3'd5) begin
          emit_end = cmd_r.last && (cmd_r.nreset == '0);
          done     = !cmd_r.last || (cmd_r.nreset == '0);
        end
      end
      PH_RESET: begin
        emit_end = (cnt_inc == cmd_r.nreset);
        done     = emit_end;
      end
      default: done = 1'b1;
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    busy_nxt      = busy_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_end_nxt   = out_end_r;
    if (adv) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        out_word_nxt = emit_word;
        out_end_nxt  = emit_end;
        if (done) begin
          busy_nxt = 1'b0;
        end else if (phase_r == PH_LEAD) begin
          phase_nxt = PH_COLOUR;
          cnt_nxt   = '0;
        end else if (phase_r == PH_COLOUR && cnt_r[2:0] == 3'd5) begin
          phase_nxt = PH_RESET;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end
    // next pixel loads while the last word of this one goes out
    if (pop_valid && pop_ready) begin
      cmd_nxt   = pop_cmd;
      busy_nxt  = 1'b1;
      phase_nxt = pop_cmd.lead ? PH_LEAD : PH_COLOUR;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_word_r <= out_word_nxt;
    out_end_r  <= out_end_nxt;
    cnt_r      <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_LEAD;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/led_strip_spi_bit_encoder.sv
`default_nettype none

// Pixel to SPI line word encoder for one-wire LED strips. Each accepted pixel beat
// becomes six 16-bit words, one per colour nibble, high nibble first, in green-red-blue
// order or red-green-blue when rgb_order is set; each data bit is stretched to four
// line bits and words go out lsb first. The first pixel of a frame is preceded by one
// zero word, and the last pixel is followed by reset_words zero words (values above
// 32 act as 32), frame_end marking the final word. The output sequencer sends one word
// per cycle while the output is not stalled; a short command queue lets new pixels be
// taken while earlier ones are still being sent. Configuration is taken at any time
// but should only change while the encoder is idle.

module led_strip_spi_bit_encoder
  import lsse_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  lsse_pix_if.sink     in_pix,
  lsse_word_if.source  out_word,
  lsse_cfg_if.sink     cfg_wr
);

  lsse_cmd_t push_cmd, pop_cmd;
  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;

  lsse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix        (in_pix),
    .cfg        (cfg_wr),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  lsse_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  lsse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .word      (out_word)
  );

endmodule

`default_nettype wire

### rtl/lsse_checker.sv
`default_nettype none

module lsse_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_line_word,
  input wire logic        out_frame_end
);

  // a stalled output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_word) && $stable(out_frame_end))
    else $error("output beat changed while stalled");

  // every word is either all zero or four well-formed line nibbles
  a_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_word == 16'h0000) ||
                  (((out_line_word & 16'h1111) == 16'h1111) &&
                   ((out_line_word & 16'h8888) == 16'h0000)))
    else $error("malformed line word");

  // nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // no pixel is taken during reset
  a_reset_no_accept: assert property (@(posedge clk)
    !rst_n |-> !(in_valid && in_ready))
    else $error("pixel accepted in reset");

endmodule

bind led_strip_spi_bit_encoder lsse_checker u_lsse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_pix.valid),
  .in_ready      (in_pix.ready),
  .out_valid     (out_word.valid),
  .out_ready     (out_word.ready),
  .out_line_word (out_word.line_word),
  .out_frame_end (out_word.frame_end)
);

`default_nettype wire
